// File: sv/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg: scalar Kalman filter shared definitions
// Fixed-point formats, widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int REG_WIDTH  = 32;
    localparam int CFG_IDX_W  = 2;

    localparam int ACC_W  = ((DATA_WIDTH > REG_WIDTH) ? DATA_WIDTH : REG_WIDTH) + 1;
    localparam int REM_W  = ACC_W + 1;
    localparam int GAIN_W = FRAC_BITS + 1;
    localparam int MAG_W  = DATA_WIDTH + 1;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int CORR_W = PROD_W - FRAC_BITS;
    localparam int CNT_W  = $clog2(FRAC_BITS);

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = CFG_IDX_W'(1);

    localparam logic [REG_WIDTH-1:0] PROCESS_NOISE_RST = REG_WIDTH'(1310720);
    localparam logic [REG_WIDTH-1:0] MEASURE_NOISE_RST = REG_WIDTH'(13107200);

    localparam logic [GAIN_W-1:0]     GAIN_ONE     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [DATA_WIDTH-1:0] VARIANCE_RST = DATA_WIDTH'(GAIN_ONE);

endpackage

// File: sv/scalar_kalman_filter_top.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top: one-dimensional fixed-point Kalman filter
// One signed measurement in, one filtered estimate out, per transfer.
// ----------------------------------------------------------------------------
// Each accepted measurement runs through a small sequencer: predict the
// variance, set up the gain divide, run a restoring divider (one quotient
// bit a cycle), then use one shared multiplier twice (correction, then new
// variance) and hand over the result. The divide is skipped when the divisor
// is zero or the measurement noise is zero. The input is stalled until the
// sequencer is back in idle; a result still waiting on the output does not
// hold off the next measurement, only the hand-over of its result.
// Noise registers are written through cfg_wr_en/cfg_index/cfg_data; the user
// must write them only while idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [skf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [skf_pkg::REG_WIDTH-1:0]           cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [skf_pkg::DATA_WIDTH-1:0]   measurement,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [skf_pkg::DATA_WIDTH-1:0]   estimate_out
);
    import skf_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int F = FRAC_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL_E = 3'd3;
    localparam logic [2:0] ST_UPD_E = 3'd4;
    localparam logic [2:0] ST_UPD_V = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]           state_reg,    state_next;
    logic [REG_WIDTH-1:0] q_reg,        q_next;
    logic [REG_WIDTH-1:0] r_reg,        r_next;
    logic [W-1:0]         est_reg,      est_next;
    logic [W-1:0]         var_reg,      var_next;
    logic [W-1:0]         meas_reg,     meas_next;
    logic [W-1:0]         pred_reg,     pred_next;
    logic [ACC_W-1:0]     den_reg,      den_next;
    logic [REM_W-1:0]     rem_reg,      rem_next;
    logic [GAIN_W-1:0]    gain_reg,     gain_next;
    logic [MAG_W-1:0]     mag_reg,      mag_next;
    logic                 neg_reg,      neg_next;
    logic [CNT_W-1:0]     cnt_reg,      cnt_next;
    logic [PROD_W-1:0]    prod_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [W-1:0]         out_data_reg,  out_data_next;

    logic [ACC_W-1:0]  pred_sum;
    logic [ACC_W-1:0]  den_sum;
    logic [REM_W-1:0]  rem_shift;
    logic              rem_ge;
    logic [MAG_W-1:0]  diff;
    logic [MAG_W-1:0]  mul_a;
    logic [GAIN_W-1:0] mul_b;
    logic [CORR_W-1:0] corr;
    logic [W+1:0]      est_ext;
    logic [W+1:0]      est_sum;
    logic              in_xfer;

    assign in_stall     = (state_reg != ST_IDLE);
    assign in_xfer      = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign estimate_out = out_data_reg;

    assign pred_sum  = ACC_W'(var_reg) + ACC_W'(q_reg);
    assign den_sum   = ACC_W'(pred_reg) + ACC_W'(r_reg);
    assign rem_shift = {rem_reg[REM_W-2:0], 1'b0};
    assign rem_ge    = (rem_shift >= REM_W'(den_reg));
    assign diff      = {meas_reg[W-1], meas_reg} - {est_reg[W-1], est_reg};
    assign mul_a     = (state_reg == ST_UPD_E) ? MAG_W'(pred_reg) : mag_reg;
    assign mul_b     = (state_reg == ST_UPD_E) ? (GAIN_ONE - gain_reg) : gain_reg;
    assign corr      = prod_reg[PROD_W-1:F];
    assign est_ext   = {{2{est_reg[W-1]}}, est_reg};
    assign est_sum   = neg_reg ? (est_ext - (W+2)'(corr)) : (est_ext + (W+2)'(corr));

    always_comb
    begin
        state_next     = state_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        est_next       = est_reg;
        var_next       = var_reg;
        meas_next      = meas_reg;
        pred_next      = pred_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        gain_next      = gain_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PROCESS_NOISE: q_next = cfg_data;
                CFG_MEASURE_NOISE: r_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    meas_next  = measurement;
                    state_next = ST_PREP;
                    if (pred_sum[ACC_W-1:W] != '0)
                    begin
                        pred_next = '1;
                    end
                    else
                    begin
                        pred_next = pred_sum[W-1:0];
                    end
                end
            end
            ST_PREP:
            begin
                den_next  = den_sum;
                rem_next  = REM_W'(pred_reg);
                cnt_next  = '0;
                neg_next  = diff[W];
                mag_next  = diff[W] ? (MAG_W'(0) - diff) : diff;
                if (den_sum == '0)
                begin
                    gain_next  = '0;
                    state_next = ST_MUL_E;
                end
                else if (ACC_W'(pred_reg) >= den_sum)
                begin
                    gain_next  = GAIN_ONE;
                    state_next = ST_MUL_E;
                end
                else
                begin
                    gain_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                gain_next = {gain_reg[GAIN_W-2:0], rem_ge};
                rem_next  = rem_ge ? (rem_shift - REM_W'(den_reg)) : rem_shift;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(F - 1))
                begin
                    state_next = ST_MUL_E;
                end
            end
            ST_MUL_E:
            begin
                state_next = ST_UPD_E;
            end
            ST_UPD_E:
            begin
                if (est_sum[W+1:W-1] != {3{est_sum[W+1]}})
                begin
                    est_next = est_sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                end
                else
                begin
                    est_next = est_sum[W-1:0];
                end
                state_next = ST_UPD_V;
            end
            ST_UPD_V:
            begin
                var_next   = prod_reg[F+W-1:F];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = est_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            q_reg         <= PROCESS_NOISE_RST;
            r_reg         <= MEASURE_NOISE_RST;
            est_reg       <= '0;
            var_reg       <= VARIANCE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            q_reg         <= q_next;
            r_reg         <= r_next;
            est_reg       <= est_next;
            var_reg       <= var_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg     <= meas_next;
        pred_reg     <= pred_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        gain_reg     <= gain_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= mul_a * mul_b;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_xfer_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_PREP))
        else $error("measurement transfer did not start the sequencer");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < REM_W'(den_reg)))
        else $error("divider remainder not below divisor");

    a_gain_max_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_E) |-> (gain_reg <= GAIN_ONE))
        else $error("gain above 1.0");

    a_var_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (var_reg <= pred_reg))
        else $error("posterior variance above predicted variance");
`endif

endmodule
